@@ hdl/ship_pkg.sv @@
package ship_pkg;
  // cache geometry and field widths
  localparam int unsigned Sets = 2048;
  localparam int unsigned Ways = 16;
  localparam int unsigned SigBits = 6;
  localparam int unsigned AddrBits = 20;
  localparam int unsigned SetW = $clog2(Sets);
  localparam int unsigned WayW = $clog2(Ways);
  localparam int unsigned RrpvMax = 3;
  localparam logic [1:0] RrpvNear = 2'd0;
  localparam logic [1:0] RrpvLong = 2'd1;
  localparam logic [1:0] RrpvDist = 2'd3;
  localparam logic [2:0] StreakMax = 3'd7;
  localparam logic [2:0] ThreshReset = 3'd4;
  localparam logic [1:0] CtrMax = 2'd3;
  localparam logic [1:0] CtrReset = 2'd1;
  localparam logic ActQuery = 1'b0;
  localparam logic ActUpdate = 1'b1;
endpackage

@@ hdl/ship_clear_seq.sv @@
module ship_clear_seq #(
  parameter int unsigned Depth = 2048
) (
  input  logic clk_i,
  input  logic rst_ni,
  output logic busy_o,
  output logic [$clog2(Depth)-1:0] addr_o
);
  import ship_pkg::*;
  localparam int unsigned AW = $clog2(Depth);
  logic [AW:0] cnt_q, cnt_d;
  logic busy_q;
  always_comb begin
    cnt_d = cnt_q + 1'b1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q <= cnt_d;
      if (cnt_d == (AW+1)'(Depth)) busy_q <= 1'b0;
    end
  end
  assign busy_o = busy_q;
  assign addr_o = cnt_q[AW-1:0];
endmodule

@@ hdl/ship_srrip_stream_bypass_policy.sv @@
// replacement policy engine: ship reuse prediction over 2-bit srrip with a per-set stride
// streaming detector. each set row (every way's rrpv and signature plus the stride state)
// lives in a row memory and the 2-bit reuse counters in a small counter memory, both read
// through a register. a word is taken in idle, its row is read in the next cycle, the
// counters of the stored and of the new signature are read in the cycle after, and the
// write-back cycle updates the row memory, and for an update word the counter memory, and
// loads the result register. a new word is taken only once the block is back in idle after
// write-back; the two dependent memory reads set this pace. the result register lets the
// next word be taken while a result waits; a result still waiting at write-back holds that
// word in write-back until it is taken. after reset a clearing pass writes every row and
// every counter while no word is taken; config writes are accepted throughout.
module ship_srrip_stream_bypass_policy (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic action_i,
  input  logic [ship_pkg::SetW-1:0] set_index_i,
  input  logic [ship_pkg::WayW-1:0] way_i,
  input  logic hit_i,
  input  logic [ship_pkg::AddrBits-1:0] address_low_i,
  input  logic [ship_pkg::SigBits-1:0] pc_signature_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [ship_pkg::WayW-1:0] victim_way_o,
  output logic streaming_o,
  output logic [1:0] inserted_rrpv_o
);
  import ship_pkg::*;
  localparam int unsigned SW = SetW;
  localparam int unsigned WW = WayW;
  localparam int unsigned SB = SigBits;
  localparam int unsigned AB = AddrBits;
  localparam int unsigned RowW = Ways*(2+SB) + 2*AB + 3;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LOOK, S_WRITE} state_e;
  state_e state_q;

  // row layout: rrpv per way, signature per way, prev address, prev stride, streak
  logic [RowW-1:0] mem_q [Sets];
  logic [RowW-1:0] rd_q, wr_row;
  logic [2:0] thresh_q;
  // reuse counter memory and its two registered read ports
  logic [1:0] ctr_q [2**SB];
  logic [1:0] old_ctr_q, new_ctr_q;

  logic clr_busy;
  logic [SW-1:0] clr_addr;
  ship_clear_seq #(.Depth(Sets)) u_clr (
    .clk_i(clk_i), .rst_ni(rst_ni), .busy_o(clr_busy), .addr_o(clr_addr));

  // latched word
  logic act_q, hit_q;
  logic [SW-1:0] set_q;
  logic [WW-1:0] way_q;
  logic [AB-1:0] addr_q;
  logic [SB-1:0] sig_q;
  logic [WW-1:0] vic_q;
  logic str_q;
  logic [1:0] ins_q;
  logic out_valid_q;
  logic wr_en;

  // unpack the row
  logic [1:0] rrpv [Ways];
  logic [SB-1:0] lsig [Ways];
  logic [AB-1:0] p_addr, p_stride, stride;
  logic [2:0] streak;
  always_comb begin
    for (int i = 0; i < Ways; i++) begin
      rrpv[i] = rd_q[i*2 +: 2];
      lsig[i] = rd_q[Ways*2 + i*SB +: SB];
    end
    p_addr = rd_q[Ways*(2+SB) +: AB];
    p_stride = rd_q[Ways*(2+SB)+AB +: AB];
    streak = rd_q[RowW-3 +: 3];
    stride = addr_q - p_addr;
  end

  // victim: aging by (3 - max) gives the lowest way of max rrpv
  logic [1:0] top;
  logic [WW-1:0] vic;
  logic [1:0] aged [Ways];
  always_comb begin
    top = '0;
    vic = '0;
    for (int i = 0; i < Ways; i++) if (rrpv[i] > top) top = rrpv[i];
    for (int i = Ways-1; i >= 0; i--) if (rrpv[i] == top) vic = WW'(i);
    for (int i = 0; i < Ways; i++) aged[i] = rrpv[i] + (2'(RrpvMax) - top);
  end

  // stride detector and update
  logic run, strm;
  logic [2:0] streak_n;
  logic [AB-1:0] stride_n;
  logic [SB-1:0] old_sig;
  logic [1:0] old_ctr_n, new_ctr, ins;
  always_comb begin
    run = (streak != 3'd0) && (stride == p_stride) && (stride != '0);
    streak_n = run ? ((streak < StreakMax) ? streak + 3'd1 : streak) : 3'd1;
    stride_n = run ? p_stride : stride;
    strm = run && (streak_n >= thresh_q);
    old_sig = lsig[way_q];
    if (hit_q) old_ctr_n = (old_ctr_q < CtrMax) ? old_ctr_q + 2'd1 : old_ctr_q;
    else old_ctr_n = (old_ctr_q != 2'd0) ? old_ctr_q - 2'd1 : old_ctr_q;
    // same signature evicted and inserted: the insertion sees the decremented count
    new_ctr = (sig_q == old_sig) ? old_ctr_n : new_ctr_q;
    if (hit_q) ins = RrpvNear;
    else if (strm || new_ctr == 2'd0) ins = RrpvDist;
    else ins = RrpvLong;
  end

  always_comb begin
    wr_row = rd_q;
    if (act_q == ActQuery) begin
      for (int i = 0; i < Ways; i++) wr_row[i*2 +: 2] = aged[i];
    end else begin
      wr_row[way_q*2 +: 2] = ins;
      if (!hit_q) wr_row[Ways*2 + way_q*SB +: SB] = sig_q;
      wr_row[Ways*(2+SB) +: AB] = addr_q;
      wr_row[Ways*(2+SB)+AB +: AB] = stride_n;
      wr_row[RowW-3 +: 3] = streak_n;
    end
  end

  logic [RowW-1:0] reset_row;
  always_comb begin
    reset_row = '0;
    for (int i = 0; i < Ways; i++) reset_row[i*2 +: 2] = RrpvDist;
  end

  // write-back only once the result register is free or being emptied
  assign wr_en = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) && !clr_busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (clr_busy) mem_q[clr_addr] <= reset_row;
    else if (wr_en) mem_q[set_q] <= wr_row;
    rd_q <= mem_q[set_q];
  end

  // counters share the clearing pass, the low address bits sweep the whole table
  always_ff @(posedge clk_i) begin
    if (clr_busy) ctr_q[clr_addr[SB-1:0]] <= CtrReset;
    else if (wr_en && act_q == ActUpdate) ctr_q[old_sig] <= old_ctr_n;
    old_ctr_q <= ctr_q[old_sig];
    new_ctr_q <= ctr_q[sig_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thresh_q <= ThreshReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) thresh_q <= cfg_data_i;
      out_valid_q <= wr_en || (out_valid_q && !out_ready_i);
      case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) state_q <= S_READ;
        S_READ: state_q <= S_LOOK;
        S_LOOK: state_q <= S_WRITE;
        S_WRITE: if (wr_en) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      hit_q <= hit_i;
      set_q <= set_index_i;
      way_q <= way_i;
      addr_q <= address_low_i;
      sig_q <= pc_signature_i;
    end
    if (wr_en) begin
      vic_q <= (act_q == ActQuery) ? vic : '0;
      str_q <= (act_q == ActUpdate) && strm;
      ins_q <= (act_q == ActUpdate) ? ins : 2'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign victim_way_o = vic_q;
  assign streaming_o = str_q;
  assign inserted_rrpv_o = ins_q;
endmodule

@@ hdl/ship_checker.sv @@
module ship_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [3:0] victim_way_o,
  input logic streaming_o,
  input logic [1:0] inserted_rrpv_o
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second word taken while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(victim_way_o) &&
      $stable(streaming_o) && $stable(inserted_rrpv_o))
    else $error("result dropped");
  a_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && streaming_o |-> (inserted_rrpv_o == 2'd3 || inserted_rrpv_o == 2'd0))
    else $error("streaming word not inserted distant");
  a_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && victim_way_o != 4'd0 |-> !streaming_o && inserted_rrpv_o == 2'd0)
    else $error("query result carries update fields");
endmodule

bind ship_srrip_stream_bypass_policy ship_checker u_chk (.*);
